@@ hdl/sse_pkg.sv @@
// Shared types, op and register codes, and sprite size tables for the scanline evaluator.
`default_nettype none
package sse_pkg;

  localparam int SPRITE_COUNT_DEF = 128;
  localparam int MAX_SPRITES_DEF  = 32;
  localparam int MAX_TILES_DEF    = 34;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] CFG_SIZE_MODE  = 3'd0;
  localparam logic [2:0] CFG_INTERLACE  = 3'd1;
  localparam logic [2:0] CFG_TILE_BASE  = 3'd2;
  localparam logic [2:0] CFG_NAME_SEL   = 3'd3;
  localparam logic [2:0] CFG_FIRST_SPR  = 3'd4;

  typedef struct packed {
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] chr;
    logic       vflip;
    logic       hflip;
    logic [1:0] prio;
    logic [2:0] pal;
    logic       nsel;
    logic       big;
  } sse_entry_t;

  function automatic logic [6:0] spr_width(input logic [2:0] mode, input logic big);
    logic [6:0] w;
    case (mode)
      3'd0: w = big ? 7'd16 : 7'd8;
      3'd1: w = big ? 7'd32 : 7'd8;
      3'd2: w = big ? 7'd64 : 7'd8;
      3'd3: w = big ? 7'd32 : 7'd16;
      3'd4: w = big ? 7'd64 : 7'd16;
      3'd5: w = big ? 7'd64 : 7'd32;
      3'd6: w = big ? 7'd32 : 7'd16;
      default: w = big ? 7'd32 : 7'd16;
    endcase
    return w;
  endfunction

  function automatic logic [6:0] spr_height(input logic [2:0] mode, input logic big,
                                            input logic il);
    logic [6:0] h;
    case (mode)
      3'd0: h = big ? 7'd16 : 7'd8;
      3'd1: h = big ? 7'd32 : 7'd8;
      3'd2: h = big ? 7'd64 : 7'd8;
      3'd3: h = big ? 7'd32 : 7'd16;
      3'd4: h = big ? 7'd64 : 7'd16;
      3'd5: h = big ? 7'd64 : 7'd32;
      3'd6: h = big ? (il ? 7'd16 : 7'd64) : 7'd32;
      default: h = big ? (il ? 7'd16 : 7'd32) : 7'd32;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

@@ hdl/sse_attr_mem.sv @@
// Sprite attribute memory with per-entry valid bits; unwritten entries read as zero.
`default_nettype none
module sse_attr_mem #(
  parameter int SPRITE_COUNT = sse_pkg::SPRITE_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(SPRITE_COUNT)-1:0] rd_addr,
  output sse_pkg::sse_entry_t                  rd_data,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(SPRITE_COUNT)-1:0] wr_addr,
  input  sse_pkg::sse_entry_t                  wr_data
);
  import sse_pkg::*;

  sse_entry_t              mem [SPRITE_COUNT];
  logic [SPRITE_COUNT-1:0] valid_r;
  sse_entry_t              data_r;
  logic                    dvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dvld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        dvld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = dvld_r ? data_r : '0;

endmodule
`default_nettype wire

@@ hdl/sprite_scanline_evaluator_unit.sv @@
// Top level: attribute table sequencer, line scan, tile list build and emission.
// Table write: a read-modify-write of one entry for a low-table byte, of four entries for a high-table byte.
// Evaluate: first_sprite_index is reduced modulo SPRITE_COUNT, then up to SPRITE_COUNT entries are scanned (one
// attribute read per cycle), then each kept sprite is set up and its tiles built, then the tiles go out.
// One transaction at a time; the shared attribute read port sets the scan rate.
// Reset clears control, flags and registers; entry valid bits make the table read zero.
`default_nettype none
module sprite_scanline_evaluator_unit #(
  parameter int SPRITE_COUNT         = sse_pkg::SPRITE_COUNT_DEF,
  parameter int MAX_SPRITES_PER_LINE = sse_pkg::MAX_SPRITES_DEF,
  parameter int MAX_TILES_PER_LINE   = sse_pkg::MAX_TILES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [9:0]  in_table_address,
  input  wire logic [7:0]  in_write_byte,
  input  wire logic [8:0]  in_scan_line,
  input  wire logic        in_odd_field,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_tile_valid,
  output logic [8:0]       out_tile_x,
  output logic [7:0]       out_tile_row,
  output logic [1:0]       out_tile_priority,
  output logic [7:0]       out_palette_base,
  output logic             out_mirror_x,
  output logic [10:0]      out_tile_index,
  output logic             out_sprite_overflow,
  output logic             out_tile_overflow,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sse_pkg::*;

  localparam int IW   = $clog2(SPRITE_COUNT);
  localparam int KW   = $clog2(SPRITE_COUNT + 1);
  localparam int ITW  = $clog2(MAX_SPRITES_PER_LINE + 1);
  localparam int SELW = (MAX_SPRITES_PER_LINE > 1) ? $clog2(MAX_SPRITES_PER_LINE) : 1;
  localparam int TCW  = $clog2(MAX_TILES_PER_LINE + 1);
  localparam int TBW  = (MAX_TILES_PER_LINE > 1) ? $clog2(MAX_TILES_PER_LINE) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_WR_RD, S_WR_WB, S_EV_MOD, S_EV_SCAN, S_SEL_RD,
    S_ATTR_RD, S_SETUP, S_TILE, S_EMIT_RD, S_EMIT_LD
  } state_t;

  typedef struct packed {
    logic [8:0]  x;
    logic [7:0]  row;
    logic [1:0]  prio;
    logic [2:0]  pal;
    logic        hflip;
    logic [10:0] idx;
  } tile_rec_t;

  state_t state_r;

  logic [2:0]  size_mode_r;
  logic        il_r;
  logic [15:0] tb_r;
  logic [1:0]  name_r;
  logic [6:0]  first_r;

  logic [9:0]  addr_r;
  logic [7:0]  wb_r;
  logic [8:0]  line_r;
  logic        field_r;
  logic [6:0]  widx_r;
  logic [1:0]  wk_r;
  logic        range_r;
  logic        time_r;

  logic [6:0]    s_r;
  logic [KW-1:0] k_r;
  logic          chk_v_r;
  logic [IW-1:0] chk_idx_r;
  logic [ITW-1:0] items_r;
  logic [ITW-1:0] rem_r;
  logic [TCW-1:0] tcnt_r;
  logic [TCW-1:0] e_r;

  sse_entry_t  ent_r;
  logic [7:0]  row_r;
  logic [10:0] base_r;
  logic [3:0]  tw_r;
  logic [2:0]  tx_r;

  logic          out_valid_r;
  tile_rec_t     out_rec_r;
  logic          out_tv_r;
  logic          out_range_r;
  logic          out_time_r;
  logic          out_last_r;

  // memories
  logic [IW-1:0] sel_mem [MAX_SPRITES_PER_LINE];
  logic [IW-1:0] sel_q;
  tile_rec_t     tbuf [MAX_TILES_PER_LINE];
  tile_rec_t     tbuf_q;

  logic          attr_rd_en;
  logic [IW-1:0] attr_rd_addr;
  sse_entry_t    attr_q;
  logic          attr_wr_en;
  sse_entry_t    attr_wd;
  logic          sel_we;
  logic [SELW-1:0] sel_ra;
  logic          tb_we;
  tile_rec_t     tb_wd;

  // combinational helpers
  logic          issue;
  logic          wr_in_range;
  logic [1:0]    hbits;
  logic [6:0]    cw, ch, chv;
  logic [9:0]    xend;
  logic [8:0]    yh;
  logic          cov;
  logic [7:0]    dy;
  logic [8:0]    y9;
  logic [7:0]    w8, h8, yv, yf;
  logic [3:0]    chry;
  logic [10:0]   tdh;
  logic [ITW-1:0] rem_m1;
  logic [8:0]    sx;
  logic          skip;
  logic [2:0]    mx;
  logic [3:0]    cx;
  logic          last_tx;
  logic          hit_room;
  logic          out_load;

  assign issue       = (k_r != KW'(SPRITE_COUNT));
  assign wr_in_range = ({1'b0, widx_r} < 8'(SPRITE_COUNT));
  assign rem_m1      = rem_r - ITW'(1);
  assign sel_ra      = rem_m1[SELW-1:0];
  assign out_load    = (state_r == S_EMIT_LD) && (!out_valid_r || out_ready);

  always_comb begin
    hbits = 2'(wb_r >> {wk_r, 1'b0});
    attr_wd = attr_q;
    if (addr_r[9]) begin
      attr_wd.x[8] = hbits[0];
      attr_wd.big  = hbits[1];
    end else begin
      case (addr_r[1:0])
        2'd0: attr_wd.x[7:0] = wb_r;
        2'd1: attr_wd.y = wb_r + 8'd1;
        2'd2: attr_wd.chr = wb_r;
        default: begin
          attr_wd.vflip = wb_r[7];
          attr_wd.hflip = wb_r[6];
          attr_wd.prio  = wb_r[5:4];
          attr_wd.pal   = wb_r[3:1];
          attr_wd.nsel  = wb_r[0];
        end
      endcase
    end
  end

  // line coverage and per-sprite setup, both from the attribute read data
  always_comb begin
    cw   = spr_width(size_mode_r, attr_q.big);
    ch   = spr_height(size_mode_r, attr_q.big, il_r);
    chv  = il_r ? (ch >> 1) : ch;
    xend = {1'b0, attr_q.x} + {3'b0, cw} - 10'd1;
    yh   = {1'b0, attr_q.y} + {2'b0, chv};
    cov  = !((attr_q.x > 9'd256) && (xend < 10'd512)) &&
           (((line_r >= {1'b0, attr_q.y}) && (line_r < yh)) ||
            (yh[8] && (line_r < {1'b0, yh[7:0]})));

    dy = line_r[7:0] - attr_q.y;
    y9 = il_r ? {dy, 1'b0} : {1'b0, dy};
    w8 = {1'b0, cw};
    h8 = {1'b0, ch};
    yv = y9[7:0];
    if (attr_q.vflip) begin
      if (cw == ch) begin
        yv = h8 - 8'd1 - y9[7:0];
      end else if (y9 < {2'b0, cw}) begin
        yv = w8 - 8'd1 - y9[7:0];
      end else begin
        yv = {w8[6:0], 1'b0} + w8 - 8'd1 - y9[7:0];
      end
    end
    yf = yv;
    if (il_r) begin
      yf = attr_q.vflip ? (yv - {7'b0, field_r}) : (yv + {7'b0, field_r});
    end
    chry = attr_q.chr[7:4] + yf[6:3];
    tdh  = tb_r[15:5] + (attr_q.nsel ? {({1'b0, name_r} + 3'd1), 8'b0} : 11'd0);
  end

  always_comb begin
    sx      = ent_r.x + {3'b0, tx_r, 3'b0};
    skip    = (ent_r.x != 9'd256) && (sx >= 9'd256) && (sx <= 9'd504);
    mx      = ent_r.hflip ? 3'(tw_r - 4'd1 - {1'b0, tx_r}) : tx_r;
    cx      = ent_r.chr[3:0] + {1'b0, mx};
    last_tx = ({1'b0, tx_r} == (tw_r - 4'd1));
    hit_room = (items_r != ITW'(MAX_SPRITES_PER_LINE));
    tb_wd.x     = sx;
    tb_wd.row   = row_r;
    tb_wd.prio  = ent_r.prio;
    tb_wd.pal   = ent_r.pal;
    tb_wd.hflip = ent_r.hflip;
    tb_wd.idx   = base_r + {7'b0, cx};
  end

  always_comb begin
    attr_rd_en   = 1'b0;
    attr_rd_addr = widx_r[IW-1:0];
    attr_wr_en   = 1'b0;
    sel_we       = 1'b0;
    tb_we        = 1'b0;
    case (state_r)
      S_WR_RD: attr_rd_en = 1'b1;
      S_WR_WB: attr_wr_en = wr_in_range;
      S_EV_SCAN: begin
        attr_rd_en   = issue;
        attr_rd_addr = s_r[IW-1:0];
        sel_we       = chk_v_r && cov && hit_room;
      end
      S_ATTR_RD: begin
        attr_rd_en   = 1'b1;
        attr_rd_addr = sel_q;
      end
      S_TILE: tb_we = !skip && (tcnt_r != TCW'(MAX_TILES_PER_LINE));
      default: ;
    endcase
  end

  sse_attr_mem #(
    .SPRITE_COUNT(SPRITE_COUNT)
  ) u_attr (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (attr_rd_en),
    .rd_addr (attr_rd_addr),
    .rd_data (attr_q),
    .wr_en   (attr_wr_en),
    .wr_addr (widx_r[IW-1:0]),
    .wr_data (attr_wd)
  );

  always_ff @(posedge clk) begin
    if (sel_we) begin
      sel_mem[items_r[SELW-1:0]] <= chk_idx_r;
    end
    sel_q <= sel_mem[sel_ra];
  end

  always_ff @(posedge clk) begin
    if (tb_we) begin
      tbuf[tcnt_r[TBW-1:0]] <= tb_wd;
    end
    tbuf_q <= tbuf[e_r[TBW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_mode_r <= '0;
      il_r        <= 1'b0;
      tb_r        <= '0;
      name_r      <= '0;
      first_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_MODE: size_mode_r <= cfg_data[2:0];
        CFG_INTERLACE: il_r        <= cfg_data[0];
        CFG_TILE_BASE: tb_r        <= cfg_data;
        CFG_NAME_SEL:  name_r      <= cfg_data[1:0];
        CFG_FIRST_SPR: first_r     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      range_r     <= 1'b0;
      time_r      <= 1'b0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
      k_r         <= '0;
      items_r     <= '0;
      rem_r       <= '0;
      tcnt_r      <= '0;
      e_r         <= '0;
      wk_r        <= '0;
      tx_r        <= '0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            addr_r  <= in_table_address;
            wb_r    <= in_write_byte;
            line_r  <= in_scan_line;
            field_r <= in_odd_field;
            case (in_op)
              OP_WRITE: begin
                wk_r    <= '0;
                widx_r  <= in_table_address[9] ? {in_table_address[4:0], 2'b00}
                                               : in_table_address[8:2];
                state_r <= S_WR_RD;
              end
              OP_EVAL: begin
                s_r     <= first_r;
                k_r     <= '0;
                chk_v_r <= 1'b0;
                items_r <= '0;
                tcnt_r  <= '0;
                state_r <= S_EV_MOD;
              end
              OP_FRAME: begin
                range_r <= 1'b0;
                time_r  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_WR_RD: state_r <= S_WR_WB;
        S_WR_WB: begin
          if (addr_r[9] && (wk_r != 2'd3)) begin
            wk_r    <= wk_r + 2'd1;
            widx_r  <= widx_r + 7'd1;
            state_r <= S_WR_RD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EV_MOD: begin
          if ({1'b0, s_r} >= 8'(SPRITE_COUNT)) begin
            s_r <= s_r - 7'(SPRITE_COUNT);
          end else begin
            state_r <= S_EV_SCAN;
          end
        end
        S_EV_SCAN: begin
          chk_v_r   <= issue;
          chk_idx_r <= s_r[IW-1:0];
          if (issue) begin
            k_r <= k_r + KW'(1);
            s_r <= ({1'b0, s_r} == 8'(SPRITE_COUNT - 1)) ? 7'd0 : s_r + 7'd1;
          end
          if (chk_v_r && cov && !hit_room) begin
            range_r <= 1'b1;
            rem_r   <= items_r;
            state_r <= S_SEL_RD;
          end else begin
            if (chk_v_r && cov) begin
              items_r <= items_r + ITW'(1);
            end
            if (!issue && !chk_v_r) begin
              rem_r   <= items_r;
              e_r     <= '0;
              state_r <= (items_r == '0) ? S_EMIT_RD : S_SEL_RD;
            end
          end
        end
        S_SEL_RD:  state_r <= S_ATTR_RD;
        S_ATTR_RD: state_r <= S_SETUP;
        S_SETUP: begin
          ent_r   <= attr_q;
          row_r   <= yf;
          base_r  <= tdh + {3'b0, chry, 4'b0};
          tw_r    <= cw[6:3];
          tx_r    <= '0;
          state_r <= S_TILE;
        end
        S_TILE: begin
          if (!skip && (tcnt_r == TCW'(MAX_TILES_PER_LINE))) begin
            time_r <= 1'b1;
          end else if (!skip) begin
            tcnt_r <= tcnt_r + TCW'(1);
          end
          if ((!skip && (tcnt_r == TCW'(MAX_TILES_PER_LINE))) || last_tx) begin
            rem_r <= rem_m1;
            e_r   <= '0;
            state_r <= (rem_r == ITW'(1)) ? S_EMIT_RD : S_SEL_RD;
          end else begin
            tx_r <= tx_r + 3'd1;
          end
        end
        S_EMIT_RD: state_r <= S_EMIT_LD;
        S_EMIT_LD: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_range_r <= range_r;
            out_time_r  <= time_r;
            if (tcnt_r == '0) begin
              out_tv_r   <= 1'b0;
              out_rec_r  <= '0;
              out_last_r <= 1'b1;
              state_r    <= S_IDLE;
            end else begin
              out_tv_r   <= 1'b1;
              out_rec_r  <= tbuf_q;
              out_last_r <= (e_r == tcnt_r - TCW'(1));
              e_r        <= e_r + TCW'(1);
              state_r    <= (e_r == tcnt_r - TCW'(1)) ? S_IDLE : S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready            = rst_n && (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_tile_valid      = out_tv_r;
  assign out_tile_x          = out_rec_r.x;
  assign out_tile_row        = out_rec_r.row;
  assign out_tile_priority   = out_rec_r.prio;
  assign out_palette_base    = out_tv_r ? {1'b1, out_rec_r.pal, 4'b0000} : 8'd0;
  assign out_mirror_x        = out_rec_r.hflip;
  assign out_tile_index      = out_rec_r.idx;
  assign out_sprite_overflow = out_range_r;
  assign out_tile_overflow   = out_time_r;
  assign out_last            = out_last_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tile_valid |-> out_last)
    else $error("empty transaction without last");

  a_tile_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= TCW'(MAX_TILES_PER_LINE))
    else $error("tile count beyond limit");

  a_sprite_bound: assert property (@(posedge clk) disable iff (!rst_n)
    items_r <= ITW'(MAX_SPRITES_PER_LINE))
    else $error("sprite count beyond limit");

  a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_FRAME) |=> !range_r && !time_r)
    else $error("frame start did not clear flags");

endmodule
`default_nettype wire

@@ verif/tb_sprite_scanline_evaluator_unit.sv @@
// Testbench for the sprite scanline evaluator: directed and random tests against a local predictor.
module tb_sprite_scanline_evaluator_unit;
  import sse_pkg::*;

  localparam int NSPR = 128;
  localparam int MAX_SPR = 32;
  localparam int MAX_TILES = 34;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic       tile_valid;
    logic [8:0] tile_x;
    logic [7:0] tile_row;
    logic [1:0] tile_priority;
    logic [7:0] palette_base;
    logic       mirror_x;
    logic [10:0] tile_index;
    logic       sprite_overflow;
    logic       tile_overflow;
    logic       last;
  } tile_result_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [1:0] in_op = 0;
  logic [9:0] in_table_address = 0;
  logic [7:0] in_write_byte = 0;
  logic [8:0] in_scan_line = 0;
  logic in_odd_field = 0;
  logic out_valid, out_ready = 0;
  logic out_tile_valid, out_mirror_x, out_sprite_overflow, out_tile_overflow, out_last;
  logic [8:0] out_tile_x;
  logic [7:0] out_tile_row, out_palette_base;
  logic [1:0] out_tile_priority;
  logic [10:0] out_tile_index;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  sprite_scanline_evaluator_unit dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state
  sse_entry_t sprite_table [NSPR];
  logic range_sticky, time_sticky;
  logic [2:0] size_mode;
  logic interlace_on;
  logic [15:0] tile_base;
  logic [1:0] name_sel;
  logic [6:0] first_spr;
  tile_result_t pending_tiles [$];

  int unsigned small_w [8] = '{8, 8, 8, 16, 16, 32, 16, 16};
  int unsigned small_h [8] = '{8, 8, 8, 16, 16, 32, 32, 32};
  int unsigned large_w [8] = '{16, 32, 64, 32, 64, 64, 32, 32};
  int unsigned large_h [8] = '{16, 32, 64, 32, 64, 64, 64, 32};

  int failures = 0;
  int cycles = 0;
  bit no_idle = 0;

  function automatic int unsigned sprite_width(sse_entry_t e);
    return e.big ? large_w[size_mode] : small_w[size_mode];
  endfunction

  function automatic int unsigned sprite_height(sse_entry_t e);
    if (!e.big) return small_h[size_mode];
    if (interlace_on && size_mode >= 6) return 16;
    return large_h[size_mode];
  endfunction

  function automatic bit on_line(sse_entry_t e, int unsigned line);
    int unsigned w, h, y;
    w = sprite_width(e);
    h = interlace_on ? sprite_height(e) >> 1 : sprite_height(e);
    y = e.y;
    if (e.x > 256 && (e.x + w - 1) < 512) return 0;
    if (line >= y && line < y + h) return 1;
    if (y + h >= 256 && line < ((y + h) & 255)) return 1;
    return 0;
  endfunction

  function automatic void table_write(int unsigned addr, logic [7:0] data);
    int unsigned i;
    if (addr < 512) begin
      i = addr >> 2;
      case (addr & 3)
        0: sprite_table[i].x[7:0] = data;
        1: sprite_table[i].y = data + 8'd1;
        2: sprite_table[i].chr = data;
        default: begin
          sprite_table[i].vflip = data[7];
          sprite_table[i].hflip = data[6];
          sprite_table[i].prio = data[5:4];
          sprite_table[i].pal = data[3:1];
          sprite_table[i].nsel = data[0];
        end
      endcase
    end else begin
      for (int k = 0; k < 4; k++) begin
        i = ((addr & 31) << 2) + k;
        sprite_table[i].x[8] = data[2*k];
        sprite_table[i].big = data[2*k+1];
      end
    end
  endfunction

  function automatic void predict_scanline(int unsigned line, bit field);
    int unsigned found, tiles, w, h, tw, x, y, td, chrx, chry, sx, mx, pos;
    sse_entry_t e;
    tile_result_t r;
    tile_result_t fetches [$];
    int unsigned picked [$];
    found = 0;
    tiles = 0;
    for (int k = 0; k < NSPR; k++) begin
      if (!on_line(sprite_table[(first_spr + k) % NSPR], line)) continue;
      found++;
      if (found > MAX_SPR) break;
      picked.push_back((first_spr + k) % NSPR);
    end
    for (int n = picked.size() - 1; n >= 0; n--) begin
      e = sprite_table[picked[n]];
      w = sprite_width(e);
      h = sprite_height(e);
      tw = w >> 3;
      x = e.x;
      y = (line - e.y) & 255;
      if (interlace_on) y = y << 1;
      if (e.vflip) begin
        if (w == h) y = (h - 1) - y;
        else y = (y < w) ? ((w - 1) - y) : (w + ((w - 1) - (y - w)));
      end
      if (interlace_on) y = e.vflip ? y - field : y + field;
      y &= 255;
      td = tile_base;
      if (e.nsel) td = (td + 8192 + (name_sel << 13)) & 16'hffff;
      chrx = e.chr & 15;
      chry = (((e.chr >> 4) + (y >> 3)) & 15) << 4;
      for (int t = 0; t < tw; t++) begin
        sx = (x + (t << 3)) & 511;
        if (x != 256 && sx >= 256 && (sx + 7) < 512) continue;
        tiles++;
        if (tiles > MAX_TILES) break;
        mx = e.hflip ? (tw - 1) - t : t;
        pos = td + ((chry + ((chrx + mx) & 15)) << 5);
        r = '0;
        r.tile_valid = 1;
        r.tile_x = 9'(sx);
        r.tile_row = 8'(y);
        r.tile_priority = e.prio;
        r.palette_base = 8'(128 + (e.pal << 4));
        r.mirror_x = e.hflip;
        r.tile_index = 11'((pos >> 5) & 11'h7ff);
        fetches.push_back(r);
      end
    end
    if (tiles > MAX_TILES) time_sticky = 1;
    if (found > MAX_SPR) range_sticky = 1;
    if (fetches.size() == 0) fetches.push_back('0);
    foreach (fetches[k]) begin
      fetches[k].sprite_overflow = range_sticky;
      fetches[k].tile_overflow = time_sticky;
      fetches[k].last = (k == fetches.size() - 1);
      pending_tiles.push_back(fetches[k]);
    end
  endfunction

  // one transaction on the input channel; valid stays high if the next call follows at once
  task automatic send_item(logic [1:0] op, logic [9:0] addr, logic [7:0] data,
                           logic [8:0] line, logic field);
    if (!no_idle) begin
      while ($urandom_range(99) < 9) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    in_op <= op;
    in_table_address <= addr;
    in_write_byte <= data;
    in_scan_line <= line;
    in_odd_field <= field;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_WRITE: table_write(addr, data);
      OP_EVAL: predict_scanline(line, field);
      OP_FRAME: begin
        range_sticky = 0;
        time_sticky = 0;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(logic [2:0] sm, logic il, logic [15:0] tb, logic [1:0] ns,
                            logic [6:0] fs);
    logic [15:0] vals [5];
    drain();
    vals = '{sm, il, tb, ns, fs};
    for (int i = CFG_SIZE_MODE; i <= CFG_FIRST_SPR; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    size_mode = sm;
    interlace_on = il;
    tile_base = tb;
    name_sel = ns;
    first_spr = fs;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 62)
      send_item(OP_WRITE,
                10'(($urandom_range(9) < 8) ? $urandom_range(511) : $urandom_range(1023)),
                8'($urandom), 9'($urandom), 1'($urandom));
    else if (pick < 92)
      send_item(OP_EVAL, 10'($urandom), 8'($urandom),
                9'(($urandom_range(9) < 8) ? $urandom_range(261) : $urandom_range(511)),
                1'($urandom));
    else if (pick < 98)
      send_item(OP_FRAME, 10'($urandom), 8'($urandom), 9'($urandom), 1'($urandom));
    else
      send_item(OP_NOP, 10'($urandom), 8'($urandom), 9'($urandom), 1'($urandom));
  endtask

  task automatic test_reset_table();
    send_item(OP_EVAL, 0, 0, 9'd0, 0);
    send_item(OP_EVAL, 0, 0, 9'd261, 1);
    send_item(OP_FRAME, 0, 0, 0, 0);
    send_item(OP_EVAL, 0, 0, 9'd511, 0);
  endtask

  task automatic test_table_bytes();
    send_item(OP_WRITE, 10'd0, 8'hff, 0, 0);
    send_item(OP_WRITE, 10'd1, 8'hff, 0, 0);
    send_item(OP_WRITE, 10'd2, 8'hff, 0, 0);
    send_item(OP_WRITE, 10'd3, 8'hff, 0, 0);
    send_item(OP_WRITE, 10'd511, 8'h00, 0, 0);
    send_item(OP_WRITE, 10'd509, 8'h0f, 0, 0);
    send_item(OP_WRITE, 10'd512, 8'hff, 0, 0);
    send_item(OP_WRITE, 10'd543, 8'h55, 0, 0);
    send_item(OP_WRITE, 10'd1023, 8'haa, 0, 0);
    send_item(OP_NOP, 10'h3ff, 8'hff, 9'h1ff, 1);
    send_item(OP_EVAL, 0, 0, 9'd0, 1);
    send_item(OP_EVAL, 0, 0, 9'd16, 0);
  endtask

  task automatic test_overflow();
    set_config(3'd5, 1'b0, 16'h0000, 2'd0, 7'd0);
    send_item(OP_EVAL, 0, 0, 9'd3, 0);
    send_item(OP_EVAL, 0, 0, 9'd30, 0);
    send_item(OP_FRAME, 0, 0, 0, 0);
    send_item(OP_EVAL, 0, 0, 9'd100, 0);
    set_config(3'd7, 1'b1, 16'hffff, 2'd3, 7'd127);
    send_item(OP_EVAL, 0, 0, 9'd5, 1);
    send_item(OP_EVAL, 0, 0, 9'd5, 0);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(3'd0, 1'b0, 16'h0000, 2'd0, 7'd0);
        1: set_config(3'd6, 1'b1, 16'h8001, 2'd2, 7'd64);
        2: set_config(3'd2, 1'b0, 16'h7ffe, 2'd1, 7'd127);
        default: set_config(3'($urandom), 1'($urandom), 16'($urandom), 2'($urandom),
                            7'($urandom));
      endcase
      no_idle = (p == 2);
      repeat (58) send_random_item();
    end
    no_idle = 0;
  endtask

  task automatic check_field(string name, int unsigned expd, int unsigned act);
    if (expd != act) begin
      $error("%s: expected %0d, got %0d", name, expd, act);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    tile_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tiles.size() == 0) begin
        $error("unexpected transaction on result channel");
        failures++;
      end else begin
        e = pending_tiles.pop_front();
        check_field("tile_valid", e.tile_valid, out_tile_valid);
        check_field("tile_x", e.tile_x, out_tile_x);
        check_field("tile_row", e.tile_row, out_tile_row);
        check_field("tile_priority", e.tile_priority, out_tile_priority);
        check_field("palette_base", e.palette_base, out_palette_base);
        check_field("mirror_x", e.mirror_x, out_mirror_x);
        check_field("tile_index", e.tile_index, out_tile_index);
        check_field("sprite_overflow", e.sprite_overflow, out_sprite_overflow);
        check_field("tile_overflow", e.tile_overflow, out_tile_overflow);
        check_field("last", e.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_sprite_scanline_evaluator_unit failed");
      $finish;
    end
  end

  initial begin
    foreach (sprite_table[i]) sprite_table[i] = '0;
    range_sticky = 0;
    time_sticky = 0;
    size_mode = 0;
    interlace_on = 0;
    tile_base = 0;
    name_sel = 0;
    first_spr = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_reset_table();
    test_table_bytes();
    test_overflow();
    test_random_phases();
    drain();
    repeat (600) @(posedge clk);
    if (failures == 0 && pending_tiles.size() == 0)
      $display("tb_sprite_scanline_evaluator_unit passed");
    else
      $display("tb_sprite_scanline_evaluator_unit failed");
    $finish;
  end

endmodule
